### src/itseq_pkg.sv
// itseq_pkg: shared types and constants of the i2c interrupt transfer sequencer
// no dependencies; used by the channel interfaces, the top level and its checker

package itseq_pkg;

   // default width of the byte counter
   localparam int unsigned LengthBitsDefault = 16;

   // fixed widths of the request and response fields
   localparam int unsigned LengthW = 16;
   localparam int unsigned AddrW   = 7;
   localparam int unsigned FlagsW  = 7;
   localparam int unsigned ByteW   = 8;

   // event flag bit positions
   localparam int unsigned EvSb    = 0;
   localparam int unsigned EvAddr  = 1;
   localparam int unsigned EvTxe   = 2;
   localparam int unsigned EvRxne  = 3;
   localparam int unsigned EvBtf   = 4;
   localparam int unsigned EvAf    = 5;
   localparam int unsigned EvStopf = 6;

   // request command codes
   typedef enum logic {
      CMD_START = 1'b0,
      CMD_EVENT = 1'b1
   } command_type;

   // transfer phase codes, as reported on the response
   typedef enum logic [2:0] {
      PH_READY = 3'd0,
      PH_MTX   = 3'd1,
      PH_MRX   = 3'd2,
      PH_STX   = 3'd3,
      PH_SRX   = 3'd4
   } phase_type;

   typedef struct packed {
      logic                command;
      logic [1:0]          mode;
      logic [AddrW-1:0]    dev_addr;
      logic [LengthW-1:0]  length;
      logic                skip_stop;
      logic [FlagsW-1:0]   event_flags;
      logic [ByteW-1:0]    tx_byte;
      logic [ByteW-1:0]    rx_data;
   } req_type;

   typedef struct packed {
      logic                dr_write;
      logic [ByteW-1:0]    dr_value;
      logic                tx_taken;
      logic                rx_valid;
      logic [ByteW-1:0]    rx_value;
      logic                start_cond;
      logic                stop_cond;
      logic                ack_enable;
      logic                irq_enable;
      logic                done_res;
      logic [2:0]          phase;
      logic                rejected;
   } rsp_type;

endpackage

### src/itseq_if.sv
// itseq_req_if / itseq_rsp_if: valid-ready channels of the transfer sequencer
// depends on itseq_pkg for the payload types

interface itseq_req_if
   import itseq_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface itseq_rsp_if
   import itseq_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### src/i2c_interrupt_transfer_sequencer_unit.sv
// i2c_interrupt_transfer_sequencer_unit: top level of the transfer sequencer
// depends on itseq_pkg and the channel interfaces in itseq_if.sv

// Sequences one interrupt-driven I2C transfer. A start request (command 0)
// arms master tx, master rx, slave tx or slave rx; status events (command 1)
// then drive data register writes, received byte delivery, ACK and STOP
// control. Every request gives exactly one response. A request is taken into
// an input register, evaluated against the transfer state combinationally and
// the response lands in an output register, so one request is accepted per
// clock while rsp_if does not stall; the rate is set by the state update loop.
// The input register takes a new request while a response still waits on
// rsp_if.
module i2c_interrupt_transfer_sequencer_unit
   import itseq_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   itseq_req_if.sink   req_if,
   itseq_rsp_if.source rsp_if
);

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // output stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   // transfer state
   phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [AddrW-1:0]       saved_addr_ff, saved_addr_in;
   logic                   keep_bus_ff, keep_bus_in;
   logic                   ack_ff, ack_in;
   logic                   irq_ff, irq_in;

   logic out_free;
   logic advance;
   logic req_take;

   // handshake
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;
   assign req_take = req_if.valid && req_if.ready;

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_data_ff;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);
   end

   // request evaluation against the transfer state
   always_comb begin
      logic [31:0]            len_wide;
      logic [LENGTH_BITS-1:0] len;
      logic [FlagsW-1:0]      ev;
      logic                   close;
      logic                   is_master;
      logic                   two_left;
      logic [LENGTH_BITS-1:0] bl_dec;

      len_wide  = {{(32 - LengthW){1'b0}}, in_data_ff.length};
      len       = len_wide[LENGTH_BITS-1:0];
      ev        = in_data_ff.event_flags;
      close     = 1'b0;
      is_master = (phase_ff == PH_MTX) || (phase_ff == PH_MRX);
      two_left  = (33'(bytes_left_ff) == 33'd2);
      bl_dec    = bytes_left_ff - LENGTH_BITS'(1);

      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      saved_addr_in = saved_addr_ff;
      keep_bus_in   = keep_bus_ff;
      ack_in        = ack_ff;
      irq_in        = irq_ff;
      out_data_in   = '0;

      if (in_data_ff.command == CMD_START) begin
         // start request: arm a transfer or reject it
         if (phase_ff != PH_READY) begin
            out_data_in.rejected = 1'b1;
         end else begin
            phase_in      = phase_type'({1'b0, in_data_ff.mode} + 3'd1);
            bytes_left_in = len;
            saved_addr_in = in_data_ff.dev_addr;
            keep_bus_in   = in_data_ff.skip_stop;
            if ((phase_in == PH_MTX) || (phase_in == PH_MRX)) begin
               out_data_in.start_cond = 1'b1;
            end
            if (phase_in != PH_MTX) begin
               ack_in = 1'b1;
            end
            irq_in = 1'b1;
         end
      end else if (is_master) begin
         // address phase
         if (ev[EvSb]) begin
            out_data_in.dr_write = 1'b1;
            out_data_in.dr_value = {saved_addr_ff, (phase_ff == PH_MRX)};
         end
         if (ev[EvAddr] && (phase_ff == PH_MRX) && (bytes_left_ff == LENGTH_BITS'(1))) begin
            ack_in = 1'b0;
         end
         if (phase_ff == PH_MTX) begin
            // master transmit data
            if ((bytes_left_ff == '0) && ev[EvBtf] && ev[EvTxe]) begin
               close = 1'b1;
            end else if (ev[EvTxe] && (bytes_left_ff != '0) && !ev[EvSb]) begin
               out_data_in.dr_write = 1'b1;
               out_data_in.dr_value = in_data_ff.tx_byte;
               out_data_in.tx_taken = 1'b1;
               bytes_left_in        = bl_dec;
            end
         end else if (ev[EvRxne]) begin
            // master receive data, ack dropped two bytes before the end
            if (two_left) begin
               ack_in = 1'b0;
            end
            out_data_in.rx_valid = 1'b1;
            out_data_in.rx_value = in_data_ff.rx_data;
            if (bytes_left_ff != '0) begin
               bytes_left_in = bl_dec;
            end
            if ((bytes_left_ff == '0) || (bytes_left_ff == LENGTH_BITS'(1))) begin
               close = 1'b1;
            end
         end
      end else if (phase_ff == PH_STX) begin
         // slave transmit, closes on acknowledge failure
         if (ev[EvTxe] && (bytes_left_ff != '0)) begin
            out_data_in.dr_write = 1'b1;
            out_data_in.dr_value = in_data_ff.tx_byte;
            out_data_in.tx_taken = 1'b1;
            bytes_left_in        = bl_dec;
         end
         if (ev[EvAf]) begin
            close = 1'b1;
         end
      end else if (phase_ff == PH_SRX) begin
         // slave receive, count saturates at zero, closes on stop
         if (ev[EvRxne]) begin
            out_data_in.rx_valid = 1'b1;
            out_data_in.rx_value = in_data_ff.rx_data;
            if (bytes_left_ff != '0) begin
               bytes_left_in = bl_dec;
            end
         end
         if (ev[EvStopf]) begin
            close = 1'b1;
         end
      end

      // transfer close
      if (close) begin
         out_data_in.stop_cond = !keep_bus_ff;
         out_data_in.done_res  = 1'b1;
         irq_in                = 1'b0;
         if ((phase_ff == PH_STX) || (phase_ff == PH_SRX)) begin
            ack_in = 1'b0;
         end
         phase_in      = PH_READY;
         bytes_left_in = '0;
         saved_addr_in = '0;
         keep_bus_in   = 1'b0;
      end

      out_data_in.ack_enable = ack_in;
      out_data_in.irq_enable = irq_in;
      out_data_in.phase      = phase_in;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_READY;
         bytes_left_ff <= '0;
         saved_addr_ff <= '0;
         keep_bus_ff   <= 1'b0;
         ack_ff        <= 1'b0;
         irq_ff        <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff      <= phase_in;
            bytes_left_ff <= bytes_left_in;
            saved_addr_ff <= saved_addr_in;
            keep_bus_ff   <= keep_bus_in;
            ack_ff        <= ack_in;
            irq_ff        <= irq_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_if.data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

### src/itseq_checker.sv
// itseq_checker: port-level assertions for the transfer sequencer, and its bind
// depends on itseq_pkg and the top level i2c_interrupt_transfer_sequencer_unit

module itseq_checker
   import itseq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled response stays valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // a close leaves the sequencer ready with the interrupt off
   a_close_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |->
         rsp_data.phase == PH_READY && !rsp_data.irq_enable && !rsp_data.start_cond)
      else $error("close without return to ready");

   // a rejected request comes only while busy and drives nothing on the bus
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |->
         rsp_data.phase != PH_READY && !rsp_data.dr_write && !rsp_data.start_cond
         && !rsp_data.done_res)
      else $error("rejected request had side effects");

   // a start condition belongs to an armed master transfer
   a_start_master: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.start_cond |->
         (rsp_data.phase == PH_MTX || rsp_data.phase == PH_MRX) && rsp_data.irq_enable)
      else $error("start condition outside master transfer");

endmodule

bind i2c_interrupt_transfer_sequencer_unit itseq_checker u_itseq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

### tb/sv/i2c_interrupt_transfer_sequencer_unit_tb.sv
// i2c_interrupt_transfer_sequencer_unit_tb: self-checking bench for the transfer sequencer
// drives a directed table and then random transfer-shaped request streams
// depends on itseq_pkg, itseq_if.sv and the top level i2c_interrupt_transfer_sequencer_unit

`timescale 1ns / 100ps

module i2c_interrupt_transfer_sequencer_unit_tb;
   import itseq_pkg::*;

   localparam int unsigned LengthBits   = LengthBitsDefault;
   localparam int unsigned NumDirected  = 24;
   localparam int unsigned RandomItems  = 1500;
   localparam int unsigned SegmentItems = 250;
   localparam int unsigned LongHold     = 300;
   localparam int unsigned DrainCycles  = 8;
   localparam int unsigned CycleLimit   = 1000000;

   // transfer kinds carried in the mode field
   localparam logic [1:0] ModeMtx = 2'd0;
   localparam logic [1:0] ModeMrx = 2'd1;
   localparam logic [1:0] ModeStx = 2'd2;
   localparam logic [1:0] ModeSrx = 2'd3;

   // status event flags
   localparam logic [FlagsW-1:0] FlSb    = FlagsW'(1 << EvSb);
   localparam logic [FlagsW-1:0] FlAddr  = FlagsW'(1 << EvAddr);
   localparam logic [FlagsW-1:0] FlTxe   = FlagsW'(1 << EvTxe);
   localparam logic [FlagsW-1:0] FlRxne  = FlagsW'(1 << EvRxne);
   localparam logic [FlagsW-1:0] FlBtf   = FlagsW'(1 << EvBtf);
   localparam logic [FlagsW-1:0] FlAf    = FlagsW'(1 << EvAf);
   localparam logic [FlagsW-1:0] FlStopf = FlagsW'(1 << EvStopf);

   typedef struct {
      bit      typed;
      rsp_type lit;
      req_type req;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   itseq_req_if req_if ();
   itseq_rsp_if rsp_if ();

   i2c_interrupt_transfer_sequencer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #1 clock = ~clock;

   // shadow of the sequencer state
   phase_type             st_phase = PH_READY;
   logic [LengthBits-1:0] st_left  = '0;
   logic [AddrW-1:0]      st_addr  = '0;
   logic                  st_keep  = 1'b0;
   logic                  st_ack   = 1'b0;
   logic                  st_irq   = 1'b0;

   rsp_type      awaited_rsp_q [$];
   rsp_type      oldest_rsp;
   stim_row_type directed_rows [NumDirected];

   int unsigned error_count   = 0;
   int unsigned rsp_count     = 0;
   int unsigned useful_count  = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned hold_rsp_ask  = 0;

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap(int unsigned pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic req_type noisy_req();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   // ignored fields are left random on purpose
   function automatic req_type start_req(logic [1:0] mode, logic [AddrW-1:0] addr,
                                         logic [LengthW-1:0] len, logic rs);
      req_type r;
      r = noisy_req();
      r.command   = CMD_START;
      r.mode      = mode;
      r.dev_addr  = addr;
      r.length    = len;
      r.skip_stop = rs;
      return r;
   endfunction

   function automatic req_type event_req(logic [FlagsW-1:0] flags, logic [ByteW-1:0] txb,
                                         logic [ByteW-1:0] rxb);
      req_type r;
      r = noisy_req();
      r.command     = CMD_EVENT;
      r.event_flags = flags;
      r.tx_byte     = txb;
      r.rx_data     = rxb;
      return r;
   endfunction

   function automatic rsp_type plain_rsp(logic start, logic rej, logic ack, logic irq,
                                         phase_type ph);
      rsp_type o;
      o            = '0;
      o.start_cond = start;
      o.rejected   = rej;
      o.ack_enable = ack;
      o.irq_enable = irq;
      o.phase      = ph;
      return o;
   endfunction

   // close: stop unless the bus is kept, drop irq, drop ack for slave kinds
   function automatic void end_transfer(inout rsp_type o);
      o.stop_cond = !st_keep;
      st_irq      = 1'b0;
      if (st_phase == PH_STX || st_phase == PH_SRX) st_ack = 1'b0;
      st_phase   = PH_READY;
      st_left    = '0;
      st_addr    = '0;
      st_keep    = 1'b0;
      o.done_res = 1'b1;
   endfunction

   // one request through the sequencer state, giving its response
   function automatic rsp_type step_sequencer(req_type r);
      rsp_type           o;
      logic [FlagsW-1:0] ev;
      o  = '0;
      ev = r.event_flags;
      if (r.command == CMD_START) begin
         if (st_phase != PH_READY) begin
            o.rejected = 1'b1;
         end else begin
            st_phase     = phase_type'({1'b0, r.mode} + 3'd1);
            st_left      = LengthBits'(r.length);
            st_addr      = r.dev_addr;
            st_keep      = r.skip_stop;
            o.start_cond = (st_phase == PH_MTX || st_phase == PH_MRX);
            if (st_phase != PH_MTX) st_ack = 1'b1;
            st_irq = 1'b1;
         end
      end else if (st_phase == PH_MTX || st_phase == PH_MRX) begin
         // address byte goes out first and blocks a data write this step
         if (ev[EvSb]) begin
            o.dr_write = 1'b1;
            o.dr_value = {st_addr, st_phase == PH_MRX};
         end
         if (ev[EvAddr] && st_phase == PH_MRX && st_left == LengthBits'(1)) st_ack = 1'b0;
         if (st_phase == PH_MTX) begin
            if (st_left == '0 && ev[EvBtf] && ev[EvTxe]) begin
               end_transfer(o);
            end else if (ev[EvTxe] && st_left != '0 && !o.dr_write) begin
               o.dr_write = 1'b1;
               o.dr_value = r.tx_byte;
               o.tx_taken = 1'b1;
               st_left    = st_left - LengthBits'(1);
            end
         end else if (ev[EvRxne]) begin
            if (st_left == LengthBits'(2)) st_ack = 1'b0;
            o.rx_valid = 1'b1;
            o.rx_value = r.rx_data;
            if (st_left != '0) st_left = st_left - LengthBits'(1);
            if (st_left == '0) end_transfer(o);
         end
      end else if (st_phase == PH_STX) begin
         if (ev[EvTxe] && st_left != '0) begin
            o.dr_write = 1'b1;
            o.dr_value = r.tx_byte;
            o.tx_taken = 1'b1;
            st_left    = st_left - LengthBits'(1);
         end
         if (ev[EvAf]) end_transfer(o);
      end else if (st_phase == PH_SRX) begin
         // receive count saturates at zero
         if (ev[EvRxne]) begin
            o.rx_valid = 1'b1;
            o.rx_value = r.rx_data;
            if (st_left != '0) st_left = st_left - LengthBits'(1);
         end
         if (ev[EvStopf]) end_transfer(o);
      end
      o.ack_enable = st_ack;
      o.irq_enable = st_irq;
      o.phase      = st_phase;
      return o;
   endfunction

   function automatic string show_rsp(rsp_type o);
      return $sformatf({"dr=%b/%h taken=%b rx=%b/%h start=%b stop=%b ack=%b irq=%b",
                        " done=%b phase=%0d rej=%b"},
                       o.dr_write, o.dr_value, o.tx_taken, o.rx_valid, o.rx_value,
                       o.start_cond, o.stop_cond, o.ack_enable, o.irq_enable, o.done_res,
                       o.phase, o.rejected);
   endfunction

   // offer one request, hold it until taken, then log its expected response
   task automatic offer_request(req_type r, bit typed, rsp_type lit);
      rsp_type predicted;
      bit      ignored;
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      ignored   = (r.command == CMD_EVENT && st_phase == PH_READY);
      predicted = step_sequencer(r);
      awaited_rsp_q.push_back(typed ? lit : predicted);
      if (!ignored) useful_count++;
   endtask

   task automatic pause_sender();
      int unsigned n;
      n = pick_gap(send_idle_pct);
      if (n != 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_random(req_type r);
      offer_request(r, 1'b0, '0);
      pause_sender();
   endtask

   task automatic drain_responses();
      req_if.valid <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(posedge clock);
   endtask

   // one transfer: a start, then mostly well-formed events with some noise
   task automatic run_transfer();
      logic [1:0]         mode;
      logic [LengthW-1:0] len;
      logic [FlagsW-1:0]  fl;
      int unsigned        roll;
      bit                 sb_sent;
      bit                 addr_sent;
      mode = 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (mode == ModeMtx || mode == ModeMrx) begin
         len = (roll < 85) ? LengthW'($urandom_range(0, 6)) : LengthW'($urandom_range(7, 40));
      end else if (roll < 60) begin
         len = LengthW'($urandom_range(0, 6));
      end else if (roll < 90) begin
         len = LengthW'($urandom_range(7, 300));
      end else begin
         len = LengthW'($urandom);
      end
      send_random(start_req(mode, 7'($urandom), len, 1'($urandom)));
      sb_sent   = 1'b0;
      addr_sent = 1'b0;
      while (st_phase != PH_READY) begin
         roll = $urandom_range(0, 99);
         fl   = '0;
         if (roll < 4) begin
            // start while busy
            send_random(start_req(2'($urandom), 7'($urandom), 16'($urandom), 1'($urandom)));
         end else if (roll < 14) begin
            send_random(event_req(7'($urandom), 8'($urandom), 8'($urandom)));
         end else begin
            case (st_phase)
               PH_MTX: begin
                  if (!sb_sent) begin
                     fl      = FlSb | ($urandom_range(0, 1) != 0 ? FlTxe : '0);
                     sb_sent = 1'b1;
                  end else if (st_left != '0) begin
                     fl = FlTxe | ($urandom_range(0, 3) == 0 ? FlAddr : '0);
                  end else begin
                     fl = FlTxe | FlBtf;
                  end
               end
               PH_MRX: begin
                  if (!sb_sent) begin
                     fl      = FlSb;
                     sb_sent = 1'b1;
                  end else if (!addr_sent) begin
                     fl        = FlAddr;
                     addr_sent = 1'b1;
                  end else begin
                     fl = FlRxne;
                  end
               end
               PH_STX: begin
                  if (st_left != '0 && $urandom_range(0, 19) != 0) begin
                     fl = FlTxe | ($urandom_range(0, 9) == 0 ? FlAf : '0);
                  end else begin
                     fl = FlAf | ($urandom_range(0, 1) != 0 ? FlTxe : '0);
                  end
               end
               PH_SRX: begin
                  if (st_left != '0 && $urandom_range(0, 19) != 0) begin
                     fl = FlRxne | ($urandom_range(0, 9) == 0 ? FlStopf : '0);
                  end else begin
                     fl = FlStopf | ($urandom_range(0, 1) != 0 ? FlRxne : '0);
                  end
               end
               default: fl = '0;
            endcase
            send_random(event_req(fl, 8'($urandom), 8'($urandom)));
         end
      end
   endtask

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response checker against the oldest awaited response
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         rsp_count++;
         if (awaited_rsp_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("response %0d with none awaited: %s", rsp_count, show_rsp(rsp_if.data));
         end else begin
            oldest_rsp = awaited_rsp_q.pop_front();
            if (rsp_if.data !== oldest_rsp) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("response %0d mismatch", rsp_count);
                  $display("   expected %s", show_rsp(oldest_rsp));
                  $display("   actual   %s", show_rsp(rsp_if.data));
               end
            end
         end
      end
   end

   // response side: random stalls plus a long hold-off on request
   initial begin
      int unsigned n;
      int unsigned holds_served;
      holds_served = 0;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_ask != holds_served) begin
            holds_served = hold_rsp_ask;
            n            = LongHold;
         end else begin
            n = pick_gap(rsp_idle_pct);
         end
         if (n != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // request side: directed table, then random segments
   initial begin
      int unsigned seg;
      int unsigned seg_goal;
      int unsigned random_goal;
      req_if.valid = 1'b0;
      req_if.data  = '0;

      directed_rows = '{
         '{1'b1, plain_rsp(1'b0, 1'b0, 1'b0, 1'b0, PH_READY),
           event_req(7'h7F, 8'hFF, 8'hFF)},
         '{1'b1, plain_rsp(1'b1, 1'b0, 1'b0, 1'b1, PH_MTX),
           start_req(ModeMtx, 7'h7F, 16'd2, 1'b0)},
         '{1'b1, plain_rsp(1'b0, 1'b1, 1'b0, 1'b1, PH_MTX),
           start_req(ModeSrx, 7'h00, 16'hFFFF, 1'b1)},
         '{1'b0, '0, event_req(FlSb | FlTxe, 8'h00, 8'h00)},
         '{1'b0, '0, event_req(FlTxe, 8'hA5, 8'h00)},
         '{1'b0, '0, event_req(FlTxe, 8'h5A, 8'h00)},
         '{1'b0, '0, event_req(FlTxe | FlBtf, 8'h00, 8'h00)},
         '{1'b0, '0, start_req(ModeMrx, 7'h00, 16'd1, 1'b1)},
         '{1'b0, '0, event_req(FlSb, 8'h00, 8'h00)},
         '{1'b0, '0, event_req(FlAddr, 8'h00, 8'h00)},
         '{1'b0, '0, event_req(FlRxne, 8'h00, 8'hFF)},
         '{1'b0, '0, start_req(ModeMrx, 7'h2A, 16'd3, 1'b0)},
         '{1'b0, '0, event_req(FlRxne, 8'h00, 8'h00)},
         '{1'b0, '0, event_req(FlRxne, 8'h00, 8'h81)},
         '{1'b0, '0, event_req(FlRxne, 8'h00, 8'h7E)},
         '{1'b0, '0, start_req(ModeMrx, 7'h11, 16'd0, 1'b0)},
         '{1'b0, '0, event_req(FlRxne, 8'h00, 8'h99)},
         '{1'b1, plain_rsp(1'b0, 1'b0, 1'b1, 1'b1, PH_STX),
           start_req(ModeStx, 7'h33, 16'd1, 1'b0)},
         '{1'b0, '0, event_req(FlTxe | FlAf, 8'hC3, 8'h00)},
         '{1'b0, '0, start_req(ModeSrx, 7'h55, 16'd0, 1'b1)},
         '{1'b0, '0, event_req(FlRxne, 8'h00, 8'h3C)},
         '{1'b0, '0, event_req(FlStopf | FlRxne, 8'h00, 8'hC3)},
         '{1'b0, '0, start_req(ModeSrx, 7'h7F, 16'hFFFF, 1'b0)},
         '{1'b0, '0, event_req(FlStopf, 8'h00, 8'h00)}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      foreach (directed_rows[i]) begin
         offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].lit);
      end
      drain_responses();

      // random part in segments with their own idle mix
      random_goal = useful_count + RandomItems;
      seg         = 0;
      while (useful_count < random_goal) begin
         case (seg)
            0: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
            1: begin
               // long response hold while requests keep coming
               send_idle_pct = 0;
               rsp_idle_pct  = 20;
               hold_rsp_ask++;
            end
            default: begin
               send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
               rsp_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            end
         endcase
         seg_goal = useful_count + SegmentItems;
         while (useful_count < seg_goal && useful_count < random_goal) begin
            if ($urandom_range(0, 9) == 0)
               send_random(event_req(7'($urandom), 8'($urandom), 8'($urandom)));
            run_transfer();
         end
         drain_responses();
         seg++;
      end

      drain_responses();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
src/itseq_pkg.sv
src/itseq_if.sv
src/i2c_interrupt_transfer_sequencer_unit.sv
src/itseq_checker.sv
tb/sv/i2c_interrupt_transfer_sequencer_unit_tb.sv
